### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the converter top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/ucc_pkg.sv
// ----------------------------------------------------------------------------
// ucc_pkg
// Types and constants of the UTF-16 / code point converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ucc_pkg;

    localparam int SYM_W       = 21;
    localparam int UNIT_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [SYM_W-1:0] SUPP_BASE        = 21'h010000;
    localparam logic [SYM_W-1:0] MAX_CODE         = 21'h10FFFF;
    localparam logic [5:0]       HI_TAG           = 6'b110110;
    localparam logic [5:0]       LO_TAG           = 6'b110111;
    localparam logic [4:0]       SURR_TAG         = 5'b11011;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    typedef struct packed {
        logic              two;
        logic [SYM_W-1:0]  first;
        logic [UNIT_W-1:0] second;
    } job_t;

    typedef struct packed {
        logic direction;
        logic pending;
    } front_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### rtl/core/ucc_front.sv
// ----------------------------------------------------------------------------
// ucc_front
// Accepts requests, tracks surrogate state and builds at most one job per request.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_front import ucc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire logic              q_full,
    output logic                   push,
    output job_t                   push_job,
    output front_stat_t            stat
);

    logic        direction_reg;
    logic        pending_reg, pending_next;
    logic [9:0]  held_reg, held_next;
    logic        accept;
    logic        has_result;
    logic [UNIT_W-1:0] unit;
    logic        is_hi, is_lo;
    logic [SYM_W-1:0] sym_fixed;
    logic [SYM_W-1:0] diff;
    logic [SYM_W-1:0] combined;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && has_result;

    assign unit     = s_symbol[UNIT_W-1:0];
    assign is_hi    = (unit[15:10] == HI_TAG);
    assign is_lo    = (unit[15:10] == LO_TAG);
    assign combined = SUPP_BASE + {1'b0, held_reg, unit[9:0]};

    assign sym_fixed = ((s_symbol > MAX_CODE) ||
                        (s_symbol[SYM_W-1:11] == {5'b0, SURR_TAG})) ?
                       REPLACEMENT_CHAR : s_symbol;
    assign diff      = sym_fixed - SUPP_BASE;

    always_comb begin
        has_result   = 1'b0;
        push_job     = '0;
        pending_next = pending_reg;
        held_next    = held_reg;
        if (direction_reg == DIR_DECODE) begin
            if (pending_reg) begin
                pending_next = 1'b0;
                held_next    = '0;
                has_result   = 1'b1;
                if (is_lo) begin
                    push_job.first = combined;
                end else if (is_hi) begin
                    push_job.first = REPLACEMENT_CHAR;
                    pending_next   = 1'b1;
                    held_next      = unit[9:0];
                end else begin
                    push_job.two    = 1'b1;
                    push_job.first  = REPLACEMENT_CHAR;
                    push_job.second = unit;
                end
            end else if (is_hi) begin
                pending_next = 1'b1;
                held_next    = unit[9:0];
            end else begin
                has_result     = 1'b1;
                push_job.first = is_lo ? REPLACEMENT_CHAR : {5'b0, unit};
            end
        end else begin
            has_result = 1'b1;
            if (sym_fixed >= SUPP_BASE) begin
                push_job.two    = 1'b1;
                push_job.first  = {5'b0, HI_TAG, diff[19:10]};
                push_job.second = {LO_TAG, diff[9:0]};
            end else begin
                push_job.first = sym_fixed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_DECODE;
            pending_reg   <= 1'b0;
            held_reg      <= '0;
        end else if (cfg_we) begin
            direction_reg <= cfg_wdata;
            pending_reg   <= 1'b0;
            held_reg      <= '0;
        end else if (accept) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

    assign stat.direction = direction_reg;
    assign stat.pending   = pending_reg;

endmodule

`default_nettype wire

### rtl/core/ucc_queue.sv
// ----------------------------------------------------------------------------
// ucc_queue
// Short job FIFO between the front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_queue import ucc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire job_t  push_job,
    input  wire logic  pop,
    output job_t       head,
    output queue_stat_t stat
);

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ucc_back.sv
// ----------------------------------------------------------------------------
// ucc_back
// Emits one or two results per job through a single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ucc_back import ucc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire job_t              head,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   phase,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [SYM_W-1:0]       m_value,
    output logic                   m_last
);

    logic             valid_reg, valid_next;
    logic             phase_reg, phase_next;
    logic [SYM_W-1:0] value_reg, value_next;
    logic             last_reg, last_next;
    logic             out_free;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        value_next = value_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (out_free) begin
            if (phase_reg) begin
                valid_next = 1'b1;
                value_next = {5'b0, head.second};
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end else if (!q_empty) begin
                valid_next = 1'b1;
                value_next = head.first;
                last_next  = !head.two;
                phase_next = head.two;
                pop        = !head.two;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign m_valid = valid_reg;
    assign m_value = value_reg;
    assign m_last  = last_reg;
    assign phase   = phase_reg;

endmodule

`default_nettype wire

### rtl/core/utf16_codepoint_converter.sv
// ----------------------------------------------------------------------------
// utf16_codepoint_converter
// UTF-16 unit / Unicode code point converter, direction set by cfg_wdata.
// ----------------------------------------------------------------------------
// Direction 0 decodes UTF-16 units (low 16 bits of s_symbol) to code points,
// direction 1 encodes code points to UTF-16 units; malformed input gives
// U+FFFD, and m_last marks the final result of a request. The emitter drives
// one result per cycle from its output register while m_ready is high; a job
// that yields two results leaves the queue only with its second result.
// A two-entry job queue sits between the front end and the emitter. Write the
// direction only while idle; a write drops any held high surrogate.
`default_nettype none

`include "assert_macros.svh"

module utf16_codepoint_converter import ucc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [SYM_W-1:0] s_symbol,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [SYM_W-1:0]      m_value,
    output logic                  m_last
);

    logic        push;
    logic        pop;
    logic        phase;
    job_t        push_job;
    job_t        head;
    front_stat_t fstat;
    queue_stat_t qstat;

    ucc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_symbol  (s_symbol),
        .q_full    (qstat.full),
        .push      (push),
        .push_job  (push_job),
        .stat      (fstat)
    );

    ucc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    ucc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (qstat.empty),
        .pop     (pop),
        .phase   (phase),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value),
        .m_last  (m_last)
    );

    `ASSERT_IMPLIES(a_pend_decode, aclk, aresetn, fstat.pending, fstat.direction == DIR_DECODE)
    `ASSERT_IMPLIES(a_phase_job, aclk, aresetn, phase, !qstat.empty)
    `ASSERT_IMPLIES(a_push_room, aclk, aresetn, push, !qstat.full)
    `ASSERT_NEXT(a_pop_emits, aclk, aresetn, pop, m_valid && m_last)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the UTF-16 / code point converter. A clocked
// driver feeds queued requests over the valid/ready input, a clocked monitor
// predicts the code points or code units of each accepted request and checks
// every accepted result in order, including the last flag. Phases switch the
// direction and vary sender gaps, receiver stalls and long receiver holds.
// ----------------------------------------------------------------------------
module tb_top;
    import ucc_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] value;
        logic             last;
    } conv_result_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [SYM_W-1:0] s_symbol  = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [SYM_W-1:0] m_value;
    logic             m_last;

    logic [SYM_W-1:0] pending_symbols[$];
    conv_result_t     expected_results[$];

    // predictor state
    logic        conv_dir     = DIR_DECODE;
    logic        held_pending = 1'b0;
    logic [9:0]  held_bits    = '0;

    int errors         = 0;
    int sender_idle    = 0;
    int recv_stall     = 0;
    int hold_len       = 0;
    int hold_epoch     = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    logic [SYM_W-1:0] dec_directed [0:13] = '{
        21'h000000, 21'h00FFFF, 21'h1FFFFF, 21'h00D800, 21'h00DC00, 21'h00DBFF,
        21'h00DFFF, 21'h00DC00, 21'h00D800, 21'h000041, 21'h00D800, 21'h00DBFF,
        21'h1FDFFF, 21'h00DBFF
    };
    logic [SYM_W-1:0] enc_directed [0:10] = '{
        21'h000000, 21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF,
        21'h00D800, 21'h00DFFF, 21'h00D7FF, 21'h00E000, 21'h1ABCDE
    };

    utf16_codepoint_converter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_symbol  (s_symbol),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_last    (m_last)
    );

    always #10 aclk = ~aclk;

    function automatic void expect_result(logic [SYM_W-1:0] value, logic last);
        conv_result_t r;
        r.value = value;
        r.last  = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_conversion(logic [SYM_W-1:0] sym);
        logic [UNIT_W-1:0] unit;
        logic [SYM_W-1:0]  cp;
        logic [SYM_W-1:0]  d;
        logic              is_high;
        logic              is_low;
        logic              stray;
        unit    = sym[UNIT_W-1:0];
        is_high = unit >= 16'hD800 && unit <= 16'hDBFF;
        is_low  = unit >= 16'hDC00 && unit <= 16'hDFFF;
        if (conv_dir == DIR_DECODE) begin
            if (held_pending && is_low) begin
                expect_result(SUPP_BASE + {1'b0, held_bits, unit[9:0]}, 1'b1);
                held_pending = 1'b0;
                held_bits    = '0;
            end else begin
                stray        = held_pending;
                held_pending = 1'b0;
                held_bits    = '0;
                if (is_high) begin
                    if (stray) expect_result(REPLACEMENT_CHAR, 1'b1);
                    held_pending = 1'b1;
                    held_bits    = unit[9:0];
                end else begin
                    if (stray) expect_result(REPLACEMENT_CHAR, 1'b0);
                    expect_result(is_low ? REPLACEMENT_CHAR : {5'd0, unit}, 1'b1);
                end
            end
        end else begin
            cp = sym;
            if (cp > MAX_CODE || (cp >= 21'h00D800 && cp <= 21'h00DFFF))
                cp = REPLACEMENT_CHAR;
            if (cp >= SUPP_BASE) begin
                d = cp - SUPP_BASE;
                expect_result(21'h00D800 + d[19:10], 1'b0);
                expect_result(21'h00DC00 + d[9:0], 1'b1);
            end else begin
                expect_result(cp, 1'b1);
            end
        end
    endfunction

    function automatic logic [UNIT_W-1:0] rand_bmp();
        logic [UNIT_W-1:0] v;
        v = UNIT_W'($urandom_range(0, 16'hFFFF - 2048));
        if (v >= 16'hD800) v = v + 16'd2048;
        return v;
    endfunction

    // upper bits are don't-care when decoding; set them now and then
    function automatic logic [SYM_W-1:0] decode_unit(logic [UNIT_W-1:0] u);
        logic [4:0] upper;
        upper = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd0;
        return {upper, u};
    endfunction

    function automatic int queue_group(logic dir);
        int sel;
        logic [UNIT_W-1:0] hi;
        sel = $urandom_range(0, 99);
        hi  = 16'hD800 + UNIT_W'($urandom_range(0, 1023));
        if (dir == DIR_DECODE) begin
            if (sel < 35) begin
                pending_symbols.push_back(decode_unit(rand_bmp()));
                return 1;
            end else if (sel < 65) begin
                pending_symbols.push_back(decode_unit(hi));
                pending_symbols.push_back(
                    decode_unit(16'hDC00 + UNIT_W'($urandom_range(0, 1023))));
                return 2;
            end else if (sel < 75) begin
                pending_symbols.push_back(
                    decode_unit(16'hDC00 + UNIT_W'($urandom_range(0, 1023))));
                return 1;
            end else if (sel < 85) begin
                pending_symbols.push_back(decode_unit(hi));
                pending_symbols.push_back(decode_unit($urandom_range(0, 1) ? rand_bmp() :
                    16'hD800 + UNIT_W'($urandom_range(0, 1023))));
                return 2;
            end
        end else begin
            if (sel < 30) begin
                pending_symbols.push_back(SYM_W'($urandom_range(0, 16'hFFFF)));
                return 1;
            end else if (sel < 65) begin
                pending_symbols.push_back(SYM_W'($urandom_range(21'h010000, 21'h10FFFF)));
                return 1;
            end else if (sel < 75) begin
                pending_symbols.push_back(SYM_W'($urandom_range(16'hD800, 16'hDFFF)));
                return 1;
            end else if (sel < 85) begin
                pending_symbols.push_back(SYM_W'($urandom_range(21'h110000, 21'h1FFFFF)));
                return 1;
            end
        end
        pending_symbols.push_back(SYM_W'($urandom_range(0, 21'h1FFFFF)));
        return 1;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_symbols.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
                s_valid  <= 1'b1;
                s_symbol <= pending_symbols.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (hold_served != hold_epoch) begin
            hold_left   = hold_len;
            hold_served = hold_epoch;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= $urandom_range(0, 99) >= recv_stall;
        end
    end

    // monitor: check results first, then predict from this edge's request
    always @(posedge aclk) begin : monitor
        conv_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got value %h last %b",
                             $time, m_value, m_last);
                end else begin
                    want = expected_results.pop_front();
                    if (m_value !== want.value) begin
                        errors++;
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want.value, m_value);
                    end
                    if (m_last !== want.last) begin
                        errors++;
                        $display("%0t: last mismatch, expected %b, got %b",
                                 $time, want.last, m_last);
                    end
                end
            end
            if (cfg_we) begin
                conv_dir     = cfg_wdata;
                held_pending = 1'b0;
                held_bits    = '0;
            end else if (s_valid && s_ready) begin
                predict_conversion(s_symbol);
            end
        end
    end

    task automatic wait_drained();
        while (pending_symbols.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        // a held high surrogate gives no result; let the pipeline settle
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_direction(logic dir);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(logic dir, int n, int s_idle, int r_stall, int hold);
        int count;
        count = 0;
        write_direction(dir);
        sender_idle = s_idle;
        recv_stall  = r_stall;
        if (hold > 0) begin
            hold_len   = hold;
            hold_epoch = hold_epoch + 1;
        end
        while (count < n) count += queue_group(dir);
        wait_drained();
    endtask

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dec_directed[i]) pending_symbols.push_back(dec_directed[i]);
        wait_drained();
        write_direction(DIR_ENCODE);
        foreach (enc_directed[i]) pending_symbols.push_back(enc_directed[i]);
        wait_drained();

        run_phase(DIR_DECODE, 300,  0,  0,   0);
        run_phase(DIR_DECODE, 200, 67,  0,   0);
        run_phase(DIR_ENCODE, 200,  0, 67,   0);
        run_phase(DIR_ENCODE, 200, 34, 34,   0);
        run_phase(DIR_DECODE, 200,  0, 67,   0);
        run_phase(DIR_DECODE, 100,  0,  0, 300);
        run_phase(DIR_ENCODE, 150, 67,  0,   0);
        run_phase(DIR_ENCODE,  80,  0,  0, 250);
        run_phase(DIR_DECODE, 200, 34, 34,   0);

        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### utf16_codepoint_converter.f
+incdir+rtl/core
rtl/core/ucc_pkg.sv
rtl/core/ucc_front.sv
rtl/core/ucc_queue.sv
rtl/core/ucc_back.sv
rtl/core/utf16_codepoint_converter.sv
tb/sv/tb_top.sv
